[sv/swbs_pkg.sv]
// Shared types, field widths and codes for the sliding-window block sender.
package swbs_pkg;

  localparam int FILE_SIZE_W = 29;
  localparam int ID_W        = 32;
  localparam int COUNT_W     = 5;
  localparam int INDEX_W     = 12;
  localparam int OFFSET_W    = 28;
  localparam int LENGTH_W    = 17;
  localparam int ACKED_W     = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_FILE_SIZE   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSFER_ID = 1'b1;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DONE_CHK,
    ST_ISSUE,
    ST_ACK_MUL,
    ST_ACK_CHK,
    ST_SCAN_RD,
    ST_SCAN_TST
  } state_e;

  // Answer of the shared span unit: whether an offset lies inside the file, and
  // the length of the block that starts there, masked to the length field.
  typedef struct packed {
    logic                in_file;
    logic [LENGTH_W-1:0] len;
  } span_t;

endpackage

[sv/swbs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module swbs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/swbs_span_unit.sv]
// Shared compare and subtract unit: checks an offset against the file size.
module swbs_span_unit #(
  parameter int BLOCK_BYTES = 65536,
  parameter int OP_W        = 37
) (
  input  logic [OP_W-1:0]                 off_i,
  input  logic [swbs_pkg::FILE_SIZE_W-1:0] file_size_i,
  output swbs_pkg::span_t                 span_o
);
  import swbs_pkg::*;

  localparam logic [OP_W-1:0] BbOp = OP_W'(BLOCK_BYTES);

  logic [OP_W-1:0] size_ext;
  logic [OP_W-1:0] remain;
  logic [OP_W-1:0] len_full;

  assign size_ext = OP_W'(file_size_i);
  assign remain   = size_ext - off_i;
  // The final block is whatever remains of the file when that is short.
  assign len_full = (remain < BbOp) ? remain : BbOp;

  assign span_o.in_file = (off_i < size_ext);
  assign span_o.len     = len_full[LENGTH_W-1:0];

endmodule

[sv/sliding_window_block_sender.sv]
// Top level of the sliding-window block sender with selective acknowledgement.
// A request passes a done check and then issues its blocks, one word per cycle once
// the first has been held back; an ack is multiplied and checked and, when it is
// accepted, followed by a bitmap scan that moves the ack point over each acked block.
// The block takes one item at a time; busy_o drops as the last word shows.
// Reset (rst_ni low, asynchronous) clears progress, configuration registers and the sequencer.
module sliding_window_block_sender #(
  parameter int WINDOW      = 16,
  parameter int BLOCK_BYTES = 65536,
  parameter int MAX_BLOCKS  = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Item channel.
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         kind_i,
  input  logic [swbs_pkg::COUNT_W-1:0]       max_count_i,
  input  logic [swbs_pkg::ID_W-1:0]          ack_id_i,
  input  logic [swbs_pkg::INDEX_W-1:0]       ack_index_i,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [swbs_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [swbs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Result channel.
  output logic                               result_valid_o,
  output logic                               issued_o,
  output logic [swbs_pkg::INDEX_W-1:0]       block_index_o,
  output logic [swbs_pkg::OFFSET_W-1:0]      byte_offset_o,
  output logic [swbs_pkg::LENGTH_W-1:0]      block_length_o,
  output logic [swbs_pkg::ACKED_W-1:0]       acked_through_o,
  output logic                               done_res_o,
  output logic                               last_o
);
  import swbs_pkg::*;

  // Block counters hold 0..MAX_BLOCKS; the bitmap is addressed by their low bits.
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int XW      = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int YW      = (CNT_W > ACKED_W) ? CNT_W : ACKED_W;
  localparam int CW      = $clog2(WINDOW + 1);
  // Running offsets only grow while they sit inside the file, so they stay below
  // the largest file size plus one block.
  localparam int OFF_W   = $clog2((2 ** FILE_SIZE_W) + BLOCK_BYTES);
  localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
  localparam int PROD_W  = INDEX_W + BB_W;
  localparam int UW      = (PROD_W > OFF_W) ? PROD_W : OFF_W;

  localparam logic [OFF_W-1:0]  BbOff  = OFF_W'(BLOCK_BYTES);
  localparam logic [BB_W-1:0]   BbVal  = BB_W'(BLOCK_BYTES);
  localparam logic [CNT_W-1:0]  CntOne = CNT_W'(1);
  localparam logic [CW-1:0]     CwOne  = CW'(1);

  // Sequencer and item registers.
  state_e                state_q, state_d;
  logic [1:0]            kind_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         sent_q;
  logic [INDEX_W-1:0]    idx_q;
  logic                  id_ok_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  done_q;

  // Configuration registers.
  logic [FILE_SIZE_W-1:0] file_size_q;
  logic [ID_W-1:0]        tid_q;

  // Transfer progress. The offsets always equal the counters times the block size.
  logic [CNT_W-1:0]      next_q;
  logic [CNT_W-1:0]      ack_q;
  logic [OFF_W-1:0]      next_off_q;
  logic [OFF_W-1:0]      ack_off_q;

  // One issued block held back until it is known whether another one follows,
  // so that the last flag is right on the word that leaves.
  logic                  pend_v_q;
  logic [INDEX_W-1:0]    pend_idx_q;
  logic [OFFSET_W-1:0]   pend_off_q;
  logic [LENGTH_W-1:0]   pend_len_q;

  // Result registers.
  logic                  res_valid_q;
  logic                  res_issued_q;
  logic [INDEX_W-1:0]    res_idx_q;
  logic [OFFSET_W-1:0]   res_off_q;
  logic [LENGTH_W-1:0]   res_len_q;
  logic [ACKED_W-1:0]    res_acked_q;
  logic                  res_done_q;
  logic                  res_last_q;

  logic                  accept;
  logic                  cfg_we;
  logic [XW-1:0]         next_x;
  logic [XW-1:0]         idx_x;
  logic [YW-1:0]         ack_y;
  logic [CNT_W-1:0]      ack_inc;
  logic                  next_lt_max;
  logic                  ack_lt_max;
  logic                  idx_lt_max;
  logic                  idx_lt_next;
  logic                  ack_lt_next;
  logic                  win_ok;
  logic [UW-1:0]         unit_off;
  span_t                 span;
  logic                  issue_ok;
  logic                  ack_ok;
  logic                  scan_ok;
  logic                  ack_done;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [0:0]            ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [0:0]            ram_rdata;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = ~busy_o;
  assign accept      = start_i & ~busy_o;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  assign next_x      = XW'(next_q);
  assign idx_x       = XW'(idx_q);
  assign ack_y       = YW'(ack_q);
  assign ack_inc     = ack_q + CntOne;
  assign next_lt_max = (32'(next_q) < MAX_BLOCKS);
  assign ack_lt_max  = (32'(ack_q) < MAX_BLOCKS);
  assign idx_lt_max  = (32'(idx_q) < MAX_BLOCKS);
  assign idx_lt_next = (idx_x < next_x);
  assign ack_lt_next = (ack_q < next_q);
  // The ack point never passes the next block, so the difference is the
  // number of blocks in flight.
  assign win_ok      = (32'(next_q - ack_q) < WINDOW);

  // The shared span unit looks at the offset that the current step needs:
  // the next block while issuing, the acked block while checking an ack, and
  // the ack point otherwise (done check and the bitmap scan).
  always_comb begin
    case (state_q)
      ST_ISSUE:   unit_off = UW'(next_off_q);
      ST_ACK_CHK: unit_off = UW'(prod_q);
      default:    unit_off = UW'(ack_off_q);
    endcase
  end

  swbs_span_unit #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .OP_W        (UW)
  ) u_span (
    .off_i       (unit_off),
    .file_size_i (file_size_q),
    .span_o      (span)
  );

  // A block index is inside the file exactly when its offset is below the file
  // size, which spares a division for the block count.
  assign issue_ok = (sent_q < count_q) && next_lt_max && span.in_file && win_ok;
  assign ack_ok   = id_ok_q && idx_lt_next && idx_lt_max && span.in_file;
  assign ack_done = !(ack_lt_max && span.in_file);
  // Bitmap entries at or past the next block are never acked in the current
  // transfer, so the scan stops there whatever an old entry still holds.
  assign scan_ok  = ack_lt_max && span.in_file && ack_lt_next && ram_rdata[0];

  // Bitmap port use. An entry is cleared as its block is issued, so the
  // bitmap needs no clearing pass after reset or restart.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = next_x[IDX_W-1:0];
    ram_wdata = 1'b0;
    if (state_q == ST_ISSUE && issue_ok) begin
      ram_we = 1'b1;
    end else if (state_q == ST_ACK_CHK && ack_ok) begin
      ram_we    = 1'b1;
      ram_waddr = idx_x[IDX_W-1:0];
      ram_wdata = 1'b1;
    end
    // While the scan moves on, fetch the entry after the current ack point.
    if (state_q == ST_SCAN_TST) begin
      ram_raddr = ack_inc[IDX_W-1:0];
    end else begin
      ram_raddr = ack_q[IDX_W-1:0];
    end
  end

  swbs_ram #(
    .WIDTH   (1),
    .DEPTH   (MAX_BLOCKS)
  ) u_ack_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_ACK) begin
            state_d = ST_ACK_MUL;
          end else begin
            state_d = ST_DONE_CHK;
          end
        end
      end
      ST_DONE_CHK: begin
        state_d = (kind_q == KIND_REQUEST) ? ST_ISSUE : ST_IDLE;
      end
      ST_ISSUE: begin
        state_d = issue_ok ? ST_ISSUE : ST_IDLE;
      end
      ST_ACK_MUL: begin
        state_d = ST_ACK_CHK;
      end
      ST_ACK_CHK: begin
        state_d = ack_ok ? ST_SCAN_RD : ST_DONE_CHK;
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_TST;
      end
      ST_SCAN_TST: begin
        state_d = scan_ok ? ST_SCAN_TST : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers and transfer progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
      tid_q       <= '0;
      next_q      <= '0;
      ack_q       <= '0;
      next_off_q  <= '0;
      ack_off_q   <= '0;
      sent_q      <= '0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we) begin
        case (cfg_index_i)
          CFG_FILE_SIZE:   file_size_q <= cfg_data_i[FILE_SIZE_W-1:0];
          CFG_TRANSFER_ID: tid_q       <= cfg_data_i[ID_W-1:0];
          default:         tid_q       <= tid_q;
        endcase
      end
      if (accept) begin
        sent_q <= '0;
        if (kind_i == KIND_RESTART) begin
          next_q     <= '0;
          ack_q      <= '0;
          next_off_q <= '0;
          ack_off_q  <= '0;
        end
      end
      case (state_q)
        ST_DONE_CHK: begin
          if (kind_q != KIND_REQUEST) begin
            res_valid_q <= 1'b1;
          end
        end
        ST_ISSUE: begin
          if (issue_ok) begin
            pend_v_q    <= 1'b1;
            res_valid_q <= pend_v_q;
            next_q      <= next_q + CntOne;
            next_off_q  <= next_off_q + BbOff;
            sent_q      <= sent_q + CwOne;
          end else begin
            pend_v_q    <= 1'b0;
            res_valid_q <= 1'b1;
          end
        end
        ST_SCAN_TST: begin
          if (scan_ok) begin
            ack_q     <= ack_inc;
            ack_off_q <= ack_off_q + BbOff;
          end else begin
            res_valid_q <= 1'b1;
          end
        end
        default: begin
          pend_v_q <= pend_v_q;
        end
      endcase
    end
  end

  // Item capture, product, done flag and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      idx_q   <= ack_index_i;
      id_ok_q <= (ack_id_i == tid_q);
      if (32'(max_count_i) > WINDOW) begin
        count_q <= CW'(WINDOW);
      end else begin
        count_q <= CW'(max_count_i);
      end
    end
    case (state_q)
      ST_ACK_MUL: begin
        prod_q <= PROD_W'(idx_q) * PROD_W'(BbVal);
      end
      ST_DONE_CHK: begin
        done_q       <= ack_done;
        res_issued_q <= 1'b0;
        res_idx_q    <= '0;
        res_off_q    <= '0;
        res_len_q    <= '0;
        res_acked_q  <= ack_y[ACKED_W-1:0];
        res_done_q   <= ack_done;
        res_last_q   <= 1'b1;
      end
      ST_ISSUE: begin
        res_acked_q <= ack_y[ACKED_W-1:0];
        res_done_q  <= done_q;
        if (issue_ok) begin
          pend_idx_q   <= next_x[INDEX_W-1:0];
          pend_off_q   <= next_off_q[OFFSET_W-1:0];
          pend_len_q   <= span.len;
          res_issued_q <= 1'b1;
          res_idx_q    <= pend_idx_q;
          res_off_q    <= pend_off_q;
          res_len_q    <= pend_len_q;
          res_last_q   <= 1'b0;
        end else begin
          // The held block is the final word; with none held, a status word.
          res_issued_q <= pend_v_q;
          res_idx_q    <= pend_v_q ? pend_idx_q : '0;
          res_off_q    <= pend_v_q ? pend_off_q : '0;
          res_len_q    <= pend_v_q ? pend_len_q : '0;
          res_last_q   <= 1'b1;
        end
      end
      ST_SCAN_TST: begin
        res_issued_q <= 1'b0;
        res_idx_q    <= '0;
        res_off_q    <= '0;
        res_len_q    <= '0;
        res_acked_q  <= ack_y[ACKED_W-1:0];
        res_done_q   <= ack_done;
        res_last_q   <= 1'b1;
      end
      default: begin
        done_q <= done_q;
      end
    endcase
  end

  assign result_valid_o  = res_valid_q;
  assign issued_o        = res_issued_q;
  assign block_index_o   = res_idx_q;
  assign byte_offset_o   = res_off_q;
  assign block_length_o  = res_len_q;
  assign acked_through_o = res_acked_q;
  assign done_res_o      = res_done_q;
  assign last_o          = res_last_q;

`ifndef SYNTHESIS
  // The cumulative ack point never runs ahead of the next block to send.
  a_ack_behind_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_q <= next_q)
    else $error("ack point passed the next block");

  // No more than a window of blocks stands issued past the ack point.
  a_window_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(next_q - ack_q) <= WINDOW)
    else $error("blocks in flight exceed the window");

  // A word that is not the last of its item is followed at once by another.
  a_burst_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_last_q) |=> res_valid_q)
    else $error("gap inside a burst of issued blocks");

  // The last word of an item leaves with the sequencer back at rest.
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_last_q) |-> (state_q == ST_IDLE))
    else $error("last word shown while the item is still in work");

  // A held block exists only while blocks are being issued.
  a_pend_in_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (state_q == ST_ISSUE))
    else $error("held block outside the issue loop");
`endif

endmodule

[sim/swbs_predict_check.sv]
// Word predictor and comparator for the sliding-window block sender.
module swbs_predict_check
  import swbs_pkg::*;
#(
  parameter int WINDOW      = 16,
  parameter int BLOCK_BYTES = 65536,
  parameter int MAX_BLOCKS  = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [1:0]             kind_i,
  input  logic [COUNT_W-1:0]     max_count_i,
  input  logic [ID_W-1:0]        ack_id_i,
  input  logic [INDEX_W-1:0]     ack_index_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   result_valid_i,
  input  logic                   issued_i,
  input  logic [INDEX_W-1:0]     block_index_i,
  input  logic [OFFSET_W-1:0]    byte_offset_i,
  input  logic [LENGTH_W-1:0]    block_length_i,
  input  logic [ACKED_W-1:0]     acked_through_i,
  input  logic                   done_res_i,
  input  logic                   last_i,
  output int                     words_due_o,
  output int                     mismatches_o
);

  typedef struct packed {
    logic                issued;
    logic [INDEX_W-1:0]  block_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [LENGTH_W-1:0] block_length;
    logic [ACKED_W-1:0]  acked_through;
    logic                done;
    logic                last;
  } block_word_t;

  block_word_t            due_words[$];
  block_word_t            seen_word;
  block_word_t            due_word;
  logic [FILE_SIZE_W-1:0] file_bytes;
  logic [ID_W-1:0]        xfer_id;
  logic [ACKED_W-1:0]     next_block;
  logic [ACKED_W-1:0]     ack_point;
  logic [MAX_BLOCKS-1:0]  acked_map;
  int                     mismatches;

  // Number of blocks in the file, rounded up and capped at the bitmap size.
  function automatic int unsigned block_total();
    longint unsigned n;
    n = (longint'(file_bytes) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES);
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    return 32'(n);
  endfunction

  // Appends one expected word at the tail of the queue.
  function automatic void owe_word(block_word_t w);
    due_words.insert(due_words.size(), w);
  endfunction

  function automatic block_word_t status_word();
    block_word_t w;
    w               = '0;
    w.acked_through = ack_point;
    w.done          = (ack_point >= block_total());
    w.last          = 1'b1;
    return w;
  endfunction

  function automatic string describe(block_word_t w);
    return $sformatf("issued=%0d index=%0d offset=%0d length=%0d acked=%0d done=%0d last=%0d",
                     w.issued, w.block_index, w.byte_offset, w.block_length,
                     w.acked_through, w.done, w.last);
  endfunction

  task automatic advance_sender(input logic [1:0] kind, input logic [COUNT_W-1:0] count,
                                input logic [ID_W-1:0] id, input logic [INDEX_W-1:0] index);
    int unsigned     total;
    int unsigned     n;
    int unsigned     flight;
    longint unsigned off;
    longint unsigned remain;
    block_word_t     w;
    total = block_total();
    case (kind)
      KIND_REQUEST: begin
        n      = (count > WINDOW) ? WINDOW : count;
        flight = next_block - ack_point;
        if (next_block >= total) n = 0;
        else if (n > total - next_block) n = total - next_block;
        if (flight >= WINDOW) n = 0;
        else if (n > WINDOW - flight) n = WINDOW - flight;
        if (n == 0) begin
          owe_word(status_word());
        end
        for (int unsigned k = 0; k < n; k++) begin
          off    = longint'(next_block) * longint'(BLOCK_BYTES);
          remain = longint'(file_bytes) - off;
          w               = '0;
          w.issued        = 1'b1;
          w.block_index   = next_block[INDEX_W-1:0];
          w.byte_offset   = off[OFFSET_W-1:0];
          w.block_length  = (remain < BLOCK_BYTES) ? remain[LENGTH_W-1:0]
                                                   : LENGTH_W'(BLOCK_BYTES);
          w.acked_through = ack_point;
          w.done          = (ack_point >= total);
          w.last          = (k == n - 1);
          owe_word(w);
          next_block = next_block + 1'b1;
        end
      end
      KIND_ACK: begin
        // Acks for another transfer or for blocks never issued leave the map alone.
        if (id == xfer_id && index < next_block && index < total) begin
          acked_map[index] = 1'b1;
          while (ack_point < total && acked_map[ack_point]) ack_point = ack_point + 1'b1;
        end
        owe_word(status_word());
      end
      KIND_RESTART: begin
        next_block = '0;
        ack_point  = '0;
        acked_map  = '0;
        owe_word(status_word());
      end
      default: begin
        owe_word(status_word());
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_bytes = '0;
      xfer_id    = '0;
      next_block = '0;
      ack_point  = '0;
      acked_map  = '0;
      mismatches = 0;
      due_words.delete();
      words_due_o  <= 0;
      mismatches_o <= 0;
    end else begin
      if (result_valid_i) begin
        seen_word.issued        = issued_i;
        seen_word.block_index   = block_index_i;
        seen_word.byte_offset   = byte_offset_i;
        seen_word.block_length  = block_length_i;
        seen_word.acked_through = acked_through_i;
        seen_word.done          = done_res_i;
        seen_word.last          = last_i;
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %s", describe(seen_word));
        end else begin
          due_word = due_words.pop_front();
          if (seen_word !== due_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word mismatch, expected: %s", describe(due_word));
              $display("                    got: %s", describe(seen_word));
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FILE_SIZE:   file_bytes = cfg_data_i[FILE_SIZE_W-1:0];
          CFG_TRANSFER_ID: xfer_id    = cfg_data_i[ID_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        advance_sender(kind_i, max_count_i, ack_id_i, ack_index_i);
      end
      words_due_o  <= due_words.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

[sim/sliding_window_block_sender_tb.sv]
// Testbench top for the sliding-window block sender: stimulus, watchdog and verdict.
module sliding_window_block_sender_tb;
  import swbs_pkg::*;

  localparam int WINDOW       = 16;
  localparam int BLOCK_BYTES  = 65536;
  localparam int MAX_BLOCKS   = 4096;
  // Item kind that the block leaves unused; it must still answer with a status word.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Largest value the file size register can hold; far beyond the bitmap size.
  localparam logic [FILE_SIZE_W-1:0] FILE_SIZE_MAX = '1;
  localparam int RANDOM_ITEMS = 140;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk_i;
  logic                   rst_ni         = 1'b0;
  logic                   start_i        = 1'b0;
  logic                   busy_o;
  logic [1:0]             kind_i         = '0;
  logic [COUNT_W-1:0]     max_count_i    = '0;
  logic [ID_W-1:0]        ack_id_i       = '0;
  logic [INDEX_W-1:0]     ack_index_i    = '0;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i     = '0;
  logic                   result_valid_o;
  logic                   issued_o;
  logic [INDEX_W-1:0]     block_index_o;
  logic [OFFSET_W-1:0]    byte_offset_o;
  logic [LENGTH_W-1:0]    block_length_o;
  logic [ACKED_W-1:0]     acked_through_o;
  logic                   done_res_o;
  logic                   last_o;

  int                     words_due;
  int                     mismatch_count;
  int                     quiet_cycles;
  // When set, the sender never pauses; used for one long stretch of the run.
  bit                     steady;
  logic [ID_W-1:0]        cur_id;
  // Blocks that came out of the block and have not been acknowledged yet. Acks are
  // drawn from here so that most of them hit live blocks, in a random order.
  logic [INDEX_W-1:0]     open_blocks[$];

  sliding_window_block_sender #(
    .WINDOW      (WINDOW),
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .max_count_i     (max_count_i),
    .ack_id_i        (ack_id_i),
    .ack_index_i     (ack_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .issued_o        (issued_o),
    .block_index_o   (block_index_o),
    .byte_offset_o   (byte_offset_o),
    .block_length_o  (block_length_o),
    .acked_through_o (acked_through_o),
    .done_res_o      (done_res_o),
    .last_o          (last_o)
  );

  swbs_predict_check #(
    .WINDOW      (WINDOW),
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_predict_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .kind_i          (kind_i),
    .max_count_i     (max_count_i),
    .ack_id_i        (ack_id_i),
    .ack_index_i     (ack_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_i  (result_valid_o),
    .issued_i        (issued_o),
    .block_index_i   (block_index_o),
    .byte_offset_i   (byte_offset_o),
    .block_length_i  (block_length_o),
    .acked_through_i (acked_through_o),
    .done_res_i      (done_res_o),
    .last_i          (last_o),
    .words_due_o     (words_due),
    .mismatches_o    (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Record every block the sender hands out, so that later acks can name it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && issued_o) begin
      open_blocks.insert(open_blocks.size(), block_index_o);
    end
  end

  // The watchdog counts cycles in which no word moves on any channel. A correct
  // block never stays silent for long, even through the longest ack scan.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Now and then the sender drops start for a few cycles. Since start is
  // otherwise held high while the block is busy, the gap ends at a random point
  // of the current item's work.
  task automatic maybe_pause();
    int gap;
    if (!steady && $urandom_range(99) < 9) begin
      gap = $urandom_range(1, 8);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Presents one item and returns at the edge where the block takes it.
  task automatic send_item(input logic [1:0] kind, input int unsigned count,
                           input logic [ID_W-1:0] id, input int unsigned index);
    maybe_pause();
    start_i     <= 1'b1;
    kind_i      <= kind;
    max_count_i <= count[COUNT_W-1:0];
    ack_id_i    <= id;
    ack_index_i <= index[INDEX_W-1:0];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (kind == KIND_RESTART) open_blocks.delete();
  endtask

  // Lets the block finish: no item offered, no word still owed, not busy.
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0 || busy_o) @(posedge clk_i);
  endtask

  // Writes both registers back to back; only called while the block is idle.
  task automatic set_transfer(input logic [FILE_SIZE_W-1:0] size, input logic [ID_W-1:0] id);
    maybe_pause();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FILE_SIZE;
    cfg_data_i  <= CFG_DATA_W'(size);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_TRANSFER_ID;
    cfg_data_i  <= id;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_id = id;
  endtask

  // One random item. Most are live acks or requests of a sensible size; the rest
  // are noise: foreign ids, acks for arbitrary blocks, the unused kind, restarts.
  // Returns 1 when the item does real work on the transfer.
  task automatic random_item(output bit useful);
    int unsigned roll;
    int unsigned pick;
    logic [INDEX_W-1:0] blk;
    roll   = $urandom_range(99);
    useful = 1'b1;
    if (open_blocks.size() > 0 && roll < 50) begin
      pick = $urandom_range(open_blocks.size() - 1);
      blk  = open_blocks[pick];
      open_blocks.delete(pick);
      send_item(KIND_ACK, $urandom_range(31), cur_id, blk);
    end else if (roll < 85) begin
      if ($urandom_range(3) == 0) pick = $urandom_range(31);
      else pick = $urandom_range(1, WINDOW);
      send_item(KIND_REQUEST, pick, $urandom, $urandom_range(MAX_BLOCKS - 1));
    end else begin
      case ($urandom_range(3))
        0: begin
          send_item(KIND_ACK, $urandom_range(31), $urandom, $urandom_range(MAX_BLOCKS - 1));
          useful = 1'b0;
        end
        1: send_item(KIND_ACK, $urandom_range(31), cur_id, $urandom_range(MAX_BLOCKS - 1));
        2: begin
          send_item(KIND_UNUSED, $urandom_range(31), $urandom, $urandom_range(MAX_BLOCKS - 1));
          useful = 1'b0;
        end
        default: send_item(KIND_RESTART, $urandom_range(31), $urandom, $urandom_range(31));
      endcase
    end
  endtask

  initial begin
    int unsigned              done_items;
    int unsigned              phase;
    int unsigned              in_phase;
    bit                       useful;
    logic [FILE_SIZE_W-1:0]   size;

    steady = 1'b0;
    cur_id = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still at reset: empty file, so nothing can be issued and the
    // transfer counts as done at once. The unused kind must change nothing.
    send_item(KIND_REQUEST, 31, '0, 0);
    send_item(KIND_ACK, 0, '0, 0);
    send_item(KIND_UNUSED, 31, '1, MAX_BLOCKS - 1);
    send_item(KIND_RESTART, 0, '0, 0);
    wait_idle();

    // Four blocks with a short final block, and an all-ones transfer id.
    set_transfer(FILE_SIZE_W'(3 * BLOCK_BYTES + 100), '1);
    send_item(KIND_REQUEST, 0, '0, 0);
    send_item(KIND_REQUEST, 31, '0, 0);   // saturates to the window, stops at end of file
    send_item(KIND_REQUEST, 1, '0, 0);    // nothing left to issue
    send_item(KIND_ACK, 0, '0, 0);        // foreign id
    send_item(KIND_ACK, 0, '1, MAX_BLOCKS - 1); // block never issued
    send_item(KIND_ACK, 0, '1, 1);        // out of order, ack point holds
    send_item(KIND_ACK, 0, '1, 0);        // ack point jumps over both
    send_item(KIND_ACK, 0, '1, 3);
    send_item(KIND_ACK, 0, '1, 2);        // transfer done
    send_item(KIND_RESTART, 0, '0, 0);
    send_item(KIND_REQUEST, WINDOW, '0, 0);
    wait_idle();

    // A file larger than the bitmap: the count saturates. The window fills up,
    // and one ack at the bottom frees exactly one more block.
    set_transfer(FILE_SIZE_MAX, 32'h5A5A_C3C3);
    send_item(KIND_REQUEST, WINDOW, '0, 0);
    send_item(KIND_REQUEST, WINDOW, '0, 0);
    send_item(KIND_ACK, 0, 32'h5A5A_C3C3, 5);
    send_item(KIND_ACK, 0, 32'h5A5A_C3C3, 0);
    send_item(KIND_REQUEST, 31, '0, 0);
    send_item(KIND_RESTART, 31, '0, 0);
    wait_idle();

    // Random phases. Each one picks a new file size and id; progress is kept
    // across the write unless a restart comes along, so shrinking files below
    // the send pointer are covered too. Phase two runs without any pause.
    done_items = 0;
    phase      = 0;
    while (done_items < RANDOM_ITEMS) begin
      case (phase % 6)
        4:       size = FILE_SIZE_W'($urandom);
        5:       size = FILE_SIZE_W'($urandom_range(1, 12) * BLOCK_BYTES);
        default: size = FILE_SIZE_W'($urandom_range(0, 12 * BLOCK_BYTES));
      endcase
      set_transfer(size, $urandom);
      steady = (phase == 2);
      if ($urandom_range(1) == 1) send_item(KIND_RESTART, 0, '0, 0);
      in_phase = 0;
      while (in_phase < 30 && done_items < RANDOM_ITEMS) begin
        random_item(useful);
        if (useful) begin
          in_phase++;
          done_items++;
        end
      end
      wait_idle();
      phase++;
    end

    // Everything owed has arrived; give the block time to show anything extra.
    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && words_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
